[rtl/dps_pkg.sv]
// Shared types and constants of the dynamic priority scheduler.
`default_nettype none

package dps_pkg;

    localparam int ID_W         = 8;
    localparam int PRIO_W       = 8;
    localparam int TIME_W       = 16;
    localparam int TASK_COUNT_W = 5;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 8'sh80;

    // One queued task as held in the task memory.
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        needed;
        logic [TIME_W-1:0]        elapsed;
    } task_rec_t;

    // Result of one transaction apart from the task count.
    typedef struct packed {
        logic                     dispatched;
        logic [ID_W-1:0]          run_id;
        logic signed [PRIO_W-1:0] run_priority;
        logic [TIME_W-1:0]        elapsed;
        logic                     finished;
        logic                     rejected;
    } dps_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_FWD,
        ST_BWD,
        ST_PUT,
        ST_OUT
    } dps_state_t;

endpackage

`default_nettype wire

[rtl/dps_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/dps_ctrl.sv]
// Sequencer that walks the priority-ordered task memory for adds and ticks.
`default_nettype none

module dps_ctrl #(
    parameter int MAX_PROCS = 16,
    localparam int AW = $clog2(MAX_PROCS),
    localparam int CW = $clog2(MAX_PROCS + 1)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_cmd,
    input  wire logic [dps_pkg::ID_W-1:0]       in_id,
    input  wire logic signed [dps_pkg::PRIO_W-1:0] in_prio,
    input  wire logic [dps_pkg::TIME_W-1:0]     in_run_time,
    input  wire logic                           out_free,
    output logic                                res_valid,
    output dps_pkg::dps_res_t                   res,
    output logic [CW-1:0]                       count,
    output logic [AW-1:0]                       rd_addr,
    input  wire dps_pkg::task_rec_t             rd_data,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output dps_pkg::task_rec_t                  wr_data
);

    import dps_pkg::*;

    dps_state_t state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    task_rec_t     cur_reg, cur_next;
    dps_res_t      res_reg, res_next;
    logic          fin_reg, fin_next;
    logic          add_reg, add_next;

    logic [TIME_W-1:0] el_inc;
    logic              head_fin;
    logic              is_last;

    assign el_inc   = rd_data.elapsed + TIME_W'(1);
    assign head_fin = (el_inc == rd_data.needed);
    assign is_last  = (CW'(k_reg) == count_reg - CW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        k_reg   <= k_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
        fin_reg <= fin_next;
        add_reg <= add_next;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        fin_next   = fin_reg;
        add_next   = add_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        rd_addr    = k_reg + AW'(1);
        wr_en      = 1'b0;
        wr_addr    = k_reg;
        wr_data    = cur_reg;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    add_next = (in_cmd == CMD_ADD);
                    res_next = '0;
                    if (in_cmd == CMD_TICK) begin
                        if (count_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            rd_addr    = '0;
                            state_next = ST_HEAD;
                        end
                    end else if (in_run_time == '0 || count_reg == CW'(MAX_PROCS)) begin
                        res_next.rejected = 1'b1;
                        state_next        = ST_OUT;
                    end else begin
                        cur_next.id      = in_id;
                        cur_next.prio    = in_prio;
                        cur_next.needed  = in_run_time;
                        cur_next.elapsed = '0;
                        if (count_reg == '0) begin
                            k_next     = '0;
                            state_next = ST_PUT;
                        end else begin
                            // walk from the tail towards the head
                            k_next     = AW'(count_reg - CW'(1));
                            rd_addr    = AW'(count_reg - CW'(1));
                            state_next = ST_BWD;
                        end
                    end
                end
            end

            ST_HEAD: begin
                res_next.dispatched   = 1'b1;
                res_next.run_id       = rd_data.id;
                res_next.run_priority = rd_data.prio;
                res_next.elapsed      = el_inc;
                res_next.finished     = head_fin;
                fin_next              = head_fin;
                cur_next.id           = rd_data.id;
                cur_next.prio         = (rd_data.prio == PRIO_MIN) ? rd_data.prio
                                                                   : rd_data.prio - 8'sd1;
                cur_next.needed       = rd_data.needed;
                cur_next.elapsed      = el_inc;
                if (count_reg == CW'(1)) begin
                    k_next = '0;
                    if (head_fin) begin
                        count_next = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else begin
                    rd_addr    = AW'(1);
                    k_next     = AW'(1);
                    state_next = ST_FWD;
                end
            end

            // close the gap at the head; drop the decayed task in where it fits
            ST_FWD: begin
                wr_en   = 1'b1;
                wr_addr = k_reg - AW'(1);
                if (fin_reg || rd_data.prio >= cur_reg.prio) begin
                    wr_data = rd_data;
                    if (is_last) begin
                        if (fin_reg) begin
                            count_next = count_reg - CW'(1);
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_PUT;
                        end
                    end else begin
                        k_next = k_reg + AW'(1);
                    end
                end else begin
                    wr_data    = cur_reg;
                    state_next = ST_OUT;
                end
            end

            // shift lower-priority tasks back by one until the slot is found
            ST_BWD: begin
                wr_en   = 1'b1;
                wr_addr = k_reg + AW'(1);
                if (cur_reg.prio > rd_data.prio) begin
                    wr_data = rd_data;
                    if (k_reg == '0) begin
                        state_next = ST_PUT;
                    end else begin
                        k_next  = k_reg - AW'(1);
                        rd_addr = k_reg - AW'(1);
                    end
                end else begin
                    wr_data    = cur_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_OUT;
                end
            end

            ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = cur_reg;
                if (add_reg) begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res   = res_reg;
    assign count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PROCS))
        else $error("task count above table size");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_OUT) |-> !wr_en)
        else $error("memory write outside a walk");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1)
             || count_reg == $past(count_reg) - CW'(1)))
        else $error("task count moved by more than one");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FWD || state_reg == ST_BWD) |-> (CW'(k_reg) < count_reg))
        else $error("walk index beyond queued tasks");

    a_result_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> state_reg == ST_IDLE)
        else $error("result issued without return to idle");

endmodule

`default_nettype wire

[rtl/dynamic_priority_scheduler.sv]
// Dynamic priority scheduler: top level with stream ports and result register.
//
// Input channel s_*: s_tuser carries the command (add a task or one tick),
// s_tdata the task id, signed priority and needed run time of an add.
// Output channel m_*: one result transaction for every input transaction,
// in order. A tick dispatches the head of the ready queue (highest priority,
// oldest among equals), runs it one time unit and either retires it or
// re-queues it one priority step lower (floor at -128).
// Tasks are held in a single task memory kept sorted by queue position; each
// item walks over it at most once, one entry a cycle through the registered read port.
// The next input is taken once the previous result sits in the output
// register; a stalled receiver holds that result and a finished walk waits
// for the register to free up, holding s_tready low meanwhile.
// Reset empties the queue at once; the task memory is not cleared.
`default_nettype none

module dynamic_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // task_id[7:0], priority_req[15:8], run_time[31:16]
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // run_id[7:0], run_priority[15:8], elapsed[31:16],
                                        // finished[32], task_count[37:33], zero[39:38]
    output logic [1:0]       m_tuser    // dispatched[0], rejected[1]
);

    import dps_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    logic          out_free;
    logic          res_valid;
    dps_res_t      res;
    logic [CW-1:0] count;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    task_rec_t     rd_rec;
    task_rec_t     wr_rec;
    logic [$bits(task_rec_t)-1:0] rd_raw;

    logic                   m_tvalid_reg, m_tvalid_next;
    dps_res_t               res_out_reg;
    logic [TASK_COUNT_W-1:0] count_out_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_rec   = task_rec_t'(rd_raw);

    dps_ram #(
        .WIDTH ($bits(task_rec_t)),
        .DEPTH (MAX_PROCS)
    ) u_task_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    dps_ctrl #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_id       (s_tdata[7:0]),
        .in_prio     (s_tdata[15:8]),
        .in_run_time (s_tdata[31:16]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .count       (count),
        .rd_addr     (rd_addr),
        .rd_data     (rd_rec),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_rec)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_valid) begin
            res_out_reg   <= res;
            count_out_reg <= TASK_COUNT_W'(count);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, count_out_reg, res_out_reg.finished, res_out_reg.elapsed,
                       res_out_reg.run_priority, res_out_reg.run_id};
    assign m_tuser  = {res_out_reg.rejected, res_out_reg.dispatched};

endmodule

`default_nettype wire

[tb/dynamic_priority_scheduler_tb.sv]
// Self-checking testbench for the dynamic priority scheduler: stream driver, monitor, predictor.
module dynamic_priority_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dps_pkg::*;

    localparam int MAX_TASKS   = 16;
    localparam int N_ITEMS     = 1550;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 2 * (MAX_TASKS + 3);
    localparam int HOLD_CYCLES = 300;

    // Ready queue in dispatch order, head at slot 0.
    typedef struct packed {
        logic [4:0]                count;
        task_rec_t [MAX_TASKS-1:0] slots;
    } ready_tbl_t;

    typedef struct packed {
        logic                     dispatched;
        logic [ID_W-1:0]          run_id;
        logic signed [PRIO_W-1:0] run_priority;
        logic [TIME_W-1:0]        elapsed;
        logic                     finished;
        logic                     rejected;
        logic [TASK_COUNT_W-1:0]  task_count;
        logic [1:0]               reserved;
    } sched_outcome_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] data;
    } sched_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    sched_item_t    pending_items[$];
    sched_outcome_t expected_outcomes[$];
    ready_tbl_t     plan_tbl = '0;
    ready_tbl_t     live_tbl = '0;
    logic           s_hs     = 1'b0;
    int             n_sent   = 0;
    int             idle_phase;
    int             hold_left = 0;
    logic           hold_done = 1'b0;
    int             err_cnt   = 0;
    int             cycle_cnt = 0;

    dynamic_priority_scheduler #(
        .MAX_PROCS(MAX_TASKS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Place a task behind every queued task of equal or higher priority.
    function automatic ready_tbl_t enqueue_task(input ready_tbl_t tbl, input task_rec_t t);
        int pos;
        int k;
        pos = int'(tbl.count);
        for (k = int'(tbl.count) - 1; k >= 0; k--) begin
            if (t.prio > tbl.slots[k].prio)
                pos = k;
        end
        for (k = MAX_TASKS - 1; k >= 1; k--) begin
            if (k > pos && k <= int'(tbl.count))
                tbl.slots[k] = tbl.slots[k-1];
        end
        tbl.slots[pos] = t;
        tbl.count = tbl.count + 1'b1;
        return tbl;
    endfunction

    // Apply one transaction to a ready queue and work out its outcome.
    function automatic ready_tbl_t schedule_step(input ready_tbl_t tbl, input logic cmd,
                                                 input logic [31:0] data,
                                                 output sched_outcome_t res);
        task_rec_t cur;
        int k;
        res = '0;
        if (cmd == CMD_ADD) begin
            if (data[31:16] == '0 || tbl.count >= MAX_TASKS) begin
                res.rejected = 1'b1;
            end else begin
                cur.id      = data[7:0];
                cur.prio    = data[15:8];
                cur.needed  = data[31:16];
                cur.elapsed = '0;
                tbl = enqueue_task(tbl, cur);
            end
        end else if (tbl.count != 0) begin
            cur = tbl.slots[0];
            for (k = 0; k < MAX_TASKS - 1; k++)
                tbl.slots[k] = tbl.slots[k+1];
            tbl.count = tbl.count - 1'b1;
            cur.elapsed      = cur.elapsed + 1'b1;
            res.dispatched   = 1'b1;
            res.run_id       = cur.id;
            res.run_priority = cur.prio;
            res.elapsed      = cur.elapsed;
            if (cur.elapsed == cur.needed) begin
                res.finished = 1'b1;
            end else begin
                if (cur.prio != PRIO_MIN)
                    cur.prio = cur.prio - 1'b1;
                tbl = enqueue_task(tbl, cur);
            end
        end
        res.task_count = tbl.count;
        return tbl;
    endfunction

    // Queue a stimulus transaction and track the queue depth it leads to.
    task automatic plan_item(input logic cmd, input logic [31:0] data);
        sched_outcome_t unused;
        pending_items.push_back(sched_item_t'{cmd, data});
        plan_tbl = schedule_step(plan_tbl, cmd, data, unused);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    assign idle_phase = (n_sent / 150) % 4;

    // Driver: offer the next pending transaction once the current one has gone.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_hs) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >=
                    (idle_phase == 1 ? 74 : idle_phase == 3 ? 37 : 0)) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].cmd;
                s_tdata  <= pending_items[0].data;
                void'(pending_items.pop_front());
                n_sent   <= n_sent + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold-off to fill the block up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent >= 100) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= $urandom_range(0, 99) >=
                        (idle_phase == 2 ? 74 : idle_phase == 3 ? 37 : 0);
        end
    end

    // Monitor: check results first, then predict for the transaction taken this edge.
    always @(posedge aclk) begin
        sched_outcome_t got;
        sched_outcome_t want;
        if (!aresetn) begin
            s_hs     <= 1'b0;
            live_tbl = '0;
        end else begin
            s_hs <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got.dispatched   = m_tuser[0];
                got.rejected     = m_tuser[1];
                got.run_id       = m_tdata[7:0];
                got.run_priority = m_tdata[15:8];
                got.elapsed      = m_tdata[31:16];
                got.finished     = m_tdata[32];
                got.task_count   = m_tdata[37:33];
                got.reserved     = m_tdata[39:38];
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h / 0x%0h",
                             $time, m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("dispatched", want.dispatched, got.dispatched);
                    check_field("rejected", want.rejected, got.rejected);
                    check_field("run_id", want.run_id, got.run_id);
                    check_field("run_priority", want.run_priority, got.run_priority);
                    check_field("elapsed", want.elapsed, got.elapsed);
                    check_field("finished", want.finished, got.finished);
                    check_field("task_count", want.task_count, got.task_count);
                    check_field("reserved", want.reserved, got.reserved);
                end
            end
            if (s_tvalid && s_tready) begin
                live_tbl = schedule_step(live_tbl, s_tuser, s_tdata, want);
                expected_outcomes.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [15:0] rt;
        logic [7:0]  prio;
        int          add_pct;
        int          r;

        // Empty-queue tick, zero run time, priority extremes and a tie at the top.
        plan_item(CMD_TICK, $urandom);
        plan_item(CMD_ADD, {16'd0, 8'h05, 8'hAA});
        plan_item(CMD_ADD, {16'd1, 8'h7F, 8'hFF});
        plan_item(CMD_ADD, {16'd3, 8'h80, 8'h00});
        plan_item(CMD_ADD, {16'd2, 8'h81, 8'h01});
        plan_item(CMD_ADD, {16'd2, 8'h7F, 8'h02});
        // Run through decay down to the floor and one tick held at the floor.
        repeat (5) plan_item(CMD_TICK, 32'h0);
        // Fill the table, then try one more add.
        while (plan_tbl.count < MAX_TASKS) begin
            rt   = 16'($urandom_range(1, 3));
            prio = 8'($urandom);
            plan_item(CMD_ADD, {rt, prio, 8'($urandom)});
        end
        plan_item(CMD_ADD, {16'hFFFF, 8'h55, 8'h3C});

        // Random mix; add share cycles so the queue fills, drains and empties.
        while (pending_items.size() < N_ITEMS) begin
            r = (pending_items.size() / 100) % 3;
            add_pct = (r == 0) ? 15 : (r == 1) ? 45 : 75;
            if ($urandom_range(0, 99) < add_pct) begin
                if (plan_tbl.count == MAX_TASKS) begin
                    // rejected anyway, so use the full run-time range here
                    rt = 16'($urandom);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        rt = '0;
                    else if (r < 85)
                        rt = 16'($urandom_range(1, 4));
                    else
                        rt = 16'($urandom_range(1, 24));
                end
                if ($urandom_range(0, 1))
                    prio = 8'($urandom);
                else
                    prio = 8'($urandom_range(0, 6)) - 8'd3;
                plan_item(CMD_ADD, {rt, prio, 8'($urandom)});
            end else begin
                plan_item(CMD_TICK, $urandom);
            end
        end

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        while (!(pending_items.size() == 0 && !s_tvalid && expected_outcomes.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/dps_pkg.sv
rtl/dps_ram.sv
rtl/dps_ctrl.sv
rtl/dynamic_priority_scheduler.sv
tb/dynamic_priority_scheduler_tb.sv
